[sv/jhs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jacobi stencil sweep package
// Shared defaults, register indexes and limits for the stencil sweep block.
// ----------------------------------------------------------------------------
package jhs_pkg;

  // Default sizing of the grid and of the cell values.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_VALUE_BITS = 24;

  // Grid width after reset and the smallest width the block runs with.
  localparam int GRID_WIDTH_RESET = 1024;
  localparam int MIN_WIDTH        = 3;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_DEVIATION = 1'b1;

endpackage

[sv/jhs_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jacobi stencil sweep channels
// Valid/ready channels for incoming grid cells and outgoing stencil results.
// ----------------------------------------------------------------------------
interface jhs_cell_if
  import jhs_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface jhs_result_if
  import jhs_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int INDEX_BITS = $clog2(DEF_MAX_WIDTH)
) ();
  logic                       valid;
  logic                       ready;
  logic [VALUE_BITS-1:0]      new_value;
  logic [INDEX_BITS-1:0]      out_row;
  logic [INDEX_BITS-1:0]      out_col;
  logic signed [VALUE_BITS:0] max_rise;
  logic                       converged;
  logic                       last;

  modport source (output valid, output new_value, output out_row, output out_col,
                  output max_rise, output converged, output last, input ready);
  modport sink   (input valid, input new_value, input out_row, input out_col,
                  input max_rise, input converged, input last, output ready);
endinterface

[sv/jacobi_heat_stencil_sweep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jacobi heat stencil sweep
// One Jacobi five-point sweep over a square grid streamed in raster order.
// ----------------------------------------------------------------------------
// Usage: grid cells, border included, arrive in raster order on the cells
// channel, one cell per transfer. For every interior cell the block sends one
// transfer on the results channel when the cell below it arrives: the mean of
// the four neighbors, the cell position, the largest rise of a new value over
// its old value so far in this sweep, and on the final interior cell the last
// flag with the convergence flag (largest rise strictly below max_deviation).
// Cells in the first or last column and the first two rows of a grid produce nothing.
// Throughput is one cell per cycle while the results receiver does not stall.
// After the transfer of the cell that completes its neighborhood, the row store
// read is registered together with that cell into the first stage, which forms
// the four-way add, the second stage updates the running maximum, and the
// output register then holds the result.
// The row store holds {row r-2, row r-1} per column and is read ahead of the
// column written from the first stage, so read and write never meet.
// When the receiver stalls, the output register and the two stages behind it
// fill up and cells ready drops; nothing is lost or repeated.
// Reset clears the counters, the running maximum and the pipeline valid bits,
// and sets grid_width to 1024 (clamped to MAX_WIDTH) and max_deviation to zero.
// The row store is not cleared; each entry is written before it is used.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module jacobi_heat_stencil_sweep
  import jhs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int IB = $clog2(MAX_WIDTH),
  localparam int WB = $clog2(MAX_WIDTH + 1),
  localparam int CB = (WB > VALUE_BITS) ? WB : VALUE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CB-1:0]             cfg_data,
  jhs_cell_if.sink                  cells,
  jhs_result_if.source              results
);

  localparam int VB = VALUE_BITS;
  localparam int RESET_WIDTH = (GRID_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_WIDTH_RESET;

  // --------------------------------------------------------------------------
  // Configuration. The width is stored already clamped to MIN_WIDTH..MAX_WIDTH.
  // --------------------------------------------------------------------------
  logic [WB-1:0] width;
  logic [VB-1:0] max_deviation;
  logic [WB-1:0] width_wr;

  always_comb begin
    width_wr = cfg_data[WB-1:0];
    if (width_wr < WB'(MIN_WIDTH)) begin
      width_wr = WB'(MIN_WIDTH);
    end else if (width_wr > WB'(MAX_WIDTH)) begin
      width_wr = WB'(MAX_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width         <= WB'(RESET_WIDTH);
      max_deviation <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:    width         <= width_wr;
        REG_MAX_DEVIATION: max_deviation <= cfg_data[VB-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake chain: output register, second stage, first stage, input.
  // The second stage passes on a cell that yields no result without waiting.
  // --------------------------------------------------------------------------
  logic o_valid;
  logic s1_valid, s2_valid;
  logic s1_adv, s2_adv, s2_free, o_free;
  logic s2_prod;
  logic accept;

  assign o_free  = !o_valid || results.ready;
  assign s2_adv  = s2_valid && (!s2_prod || o_free);
  assign s2_free = !s2_valid || s2_adv;
  assign s1_adv  = s1_valid && s2_free;
  assign cells.ready = !s1_valid || s1_adv;
  assign accept  = cells.valid && cells.ready;

  // --------------------------------------------------------------------------
  // Raster position and per-cell flags, worked out as the cell is taken.
  // --------------------------------------------------------------------------
  logic [IB-1:0] col_cnt, row_cnt;
  logic [WB-1:0] col_w, row_w, col_inc, row_inc;
  logic [WB:0]   col_inc2;
  logic          col_wrap, row_wrap;
  logic          f_prod, f_last, f_wr, f_grid_wrap;
  logic [IB-1:0] rd_addr;

  always_comb begin
    col_w       = WB'(col_cnt);
    row_w       = WB'(row_cnt);
    col_inc     = col_w + WB'(1);
    row_inc     = row_w + WB'(1);
    col_inc2    = (WB + 1)'(col_w) + (WB + 1)'(2);
    col_wrap    = col_inc >= width;
    row_wrap    = row_inc >= width;
    // Interior: 2 <= r <= w-1 and 1 <= c <= w-2 (the cell is one row below).
    f_prod      = (row_w >= WB'(2)) && (row_inc <= width) && (col_cnt != '0) && !col_wrap;
    f_last      = (row_inc == width) && (col_inc2 == {1'b0, width});
    f_wr        = col_w < width;
    f_grid_wrap = col_wrap && row_wrap;
    // At the end of a row read column 0 ahead of the next row.
    rd_addr     = col_wrap ? '0 : col_inc[IB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_cnt <= '0;
        row_cnt <= row_wrap ? '0 : row_inc[IB-1:0];
      end else begin
        col_cnt <= col_inc[IB-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row store: entry c holds {row r-2, row r-1} at column c.
  // --------------------------------------------------------------------------
  logic [2*VB-1:0] rd_data;
  logic [VB-1:0]   rd_up, rd_mid;
  logic            mem_wr_en;
  logic [IB-1:0]   s1_col;
  logic [VB-1:0]   s1_cell;
  logic [VB-1:0]   mid_c;

  assign rd_up  = rd_data[2*VB-1:VB];
  assign rd_mid = rd_data[VB-1:0];

  jhs_row_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2 * VB),
    .ADDR_BITS (IB)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (s1_col),
    .wr_data ({mid_c, s1_cell}),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Stage 1: four-way add. The window registers hold row r-1 at columns c-1
  // and c and row r-2 at column c; column c+1 comes straight from the read.
  // --------------------------------------------------------------------------
  logic [IB-1:0]  s1_row;
  logic           s1_prod, s1_last, s1_wr, s1_wrap;
  logic [VB-1:0]  mid_cm1, up_c;
  logic [VB+1:0]  sum;
  logic [VB-1:0]  nv;
  logic [VB:0]    diff;

  assign mem_wr_en = s1_adv && s1_wr;

  always_comb begin
    sum  = (VB + 2)'(up_c) + (VB + 2)'(s1_cell) + (VB + 2)'(mid_cm1) + (VB + 2)'(rd_mid);
    nv   = sum[VB+1:2];
    diff = {1'b0, nv} - {1'b0, mid_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell <= cells.cell_value;
      s1_row  <= row_cnt;
      s1_col  <= col_cnt;
      s1_prod <= f_prod;
      s1_last <= f_last;
      s1_wr   <= f_wr;
      s1_wrap <= f_grid_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mid_cm1 <= mid_c;
      mid_c   <= rd_mid;
      up_c    <= rd_up;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: running maximum of the rise and the convergence test.
  // The maximum never drops below zero, so it is kept unsigned.
  // --------------------------------------------------------------------------
  logic [VB-1:0] s2_nv;
  logic [VB:0]   s2_diff;
  logic [IB-1:0] s2_row, s2_col;
  logic          s2_last, s2_wrap;
  logic [VB-1:0] sweep_max, max_next;
  logic          conv_next;

  always_comb begin
    max_next = sweep_max;
    if (!s2_diff[VB] && (s2_diff[VB-1:0] > sweep_max)) begin
      max_next = s2_diff[VB-1:0];
    end
    conv_next = s2_last && (max_next < max_deviation);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_prod <= 1'b0;
    end else if (s1_adv) begin
      s2_prod <= s1_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_nv   <= nv;
      s2_diff <= diff;
      s2_row  <= s1_row - IB'(1);
      s2_col  <= s1_col;
      s2_last <= s1_last;
      s2_wrap <= s1_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_max <= '0;
    end else if (s2_adv) begin
      if (s2_wrap) begin
        sweep_max <= '0;
      end else if (s2_prod) begin
        sweep_max <= max_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic [VB-1:0] o_new_value;
  logic [IB-1:0] o_row, o_col;
  logic [VB-1:0] o_max;
  logic          o_conv, o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s2_adv && s2_prod) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_prod) begin
      o_new_value <= s2_nv;
      o_row       <= s2_row;
      o_col       <= s2_col;
      o_max       <= max_next;
      o_conv      <= conv_next;
      o_last      <= s2_last;
    end
  end

  assign results.valid     = o_valid;
  assign results.new_value = o_new_value;
  assign results.out_row   = o_row;
  assign results.out_col   = o_col;
  assign results.max_rise  = $signed({1'b0, o_max});
  assign results.converged = o_conv;
  assign results.last      = o_last;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_max_cleared_on_wrap: assert property (@(posedge clk) disable iff (rst)
    s2_adv && s2_wrap |=> sweep_max == '0)
    else $error("running maximum not cleared at the end of a grid");

  a_result_reaches_output: assert property (@(posedge clk) disable iff (rst)
    s2_adv && s2_prod |=> o_valid && o_col == $past(s2_col))
    else $error("stage 2 result did not reach the output register");

  a_col_interior: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_col != '0) && (WB'(o_col) + WB'(2) <= width))
    else $error("result column outside the grid interior");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_last |-> (WB'(o_row) + WB'(2) == width) && (o_conv == (o_max < max_deviation)))
    else $error("last result not on the final interior row or wrong convergence flag");

endmodule

[sv/jhs_row_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jacobi stencil row store
// Simple dual-port synchronous memory holding the two previous grid rows.
// ----------------------------------------------------------------------------
module jhs_row_store
  import jhs_pkg::*;
#(
  parameter int DEPTH     = DEF_MAX_WIDTH,
  parameter int DATA_BITS = 2 * DEF_VALUE_BITS,
  parameter int ADDR_BITS = $clog2(DEF_MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is registered and holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
